FILE: src/bmec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the block map extent coalescer.
package bmec_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_BLOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_SECTOR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLE_SECTORS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SECTOR_NUMBER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SECTOR_COUNT  = 3'd5;

    typedef struct packed {
        logic [31:0] hole_sector;
        logic [31:0] max_number;
        logic [15:0] hole_cap;
        logic [15:0] max_count;
    } t_back_cfg;

    typedef struct packed {
        logic [31:0] start;
        logic [15:0] length;
        logic [15:0] index;
        logic        end_marker;
        logic        range_error;
        logic        last;
    } t_result;

endpackage

FILE: src/bmec_front.sv
`timescale 1ns / 1ps
// Front stage: accepts block numbers, classifies holes and computes start sectors.
module bmec_front #(
    parameter int SPB_W = 5,
    parameter int ST_W  = 38
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_block_number,
    input  logic              i_final_block,
    input  logic [SPB_W-1:0]  i_spb,
    input  logic [31:0]       i_partition_start,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ST_W+1:0]   o_data
);
    localparam int PW = 32 + SPB_W;

    logic            r_valid;
    logic [ST_W-1:0] r_start;
    logic            r_hole;
    logic            r_final;
    logic [PW-1:0]   product;
    logic [ST_W-1:0] start;

    assign product = PW'(i_block_number) * PW'(i_spb);
    assign start   = ST_W'(product) + ST_W'(i_partition_start);
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {r_hole, r_final, r_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_start <= start;
            r_hole  <= (i_block_number == 32'd0);
            r_final <= i_final_block;
        end
    end
endmodule

FILE: src/bmec_queue.sv
`timescale 1ns / 1ps
// Short queue between the front stage and the extent sequencer.
module bmec_queue #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

FILE: src/bmec_back.sv
`timescale 1ns / 1ps
// Back stage: sequencer that opens, grows, closes and emits extents one step a cycle while the output is not stalled.
module bmec_back #(
    parameter int SPB_W = 5,
    parameter int ST_W  = 38
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  logic [ST_W+1:0]     i_q_data,
    input  logic [SPB_W-1:0]    i_spb,
    input  bmec_pkg::t_back_cfg i_cfg,
    output logic                o_valid,
    input  logic                i_ready,
    output bmec_pkg::t_result   o_result
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_HOLE,
        S_DATA,
        S_FIN,
        S_ERR,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [ST_W-1:0]   r_st;
    logic              r_final;
    logic [SPB_W-1:0]  r_left;
    logic [31:0]       r_start;
    logic [15:0]       r_len;
    logic              r_open;
    logic [15:0]       r_cnt;
    logic              r_halt;
    bmec_pkg::t_result r_pend;
    logic              r_pend_v;
    bmec_pkg::t_result r_out;
    logic              r_out_v;

    logic              out_free;
    logic              emit_ok;
    logic              emit;
    logic              flush;
    bmec_pkg::t_result new_res;
    bmec_pkg::t_result close_res;
    bmec_pkg::t_result out_res;
    logic              hole_new;
    logic [15:0]       room;
    logic [15:0]       step;
    logic              data_ext;
    logic              data_err;
    logic              hole_err;

    assign out_free  = !r_out_v || i_ready;
    assign emit_ok   = !r_pend_v || out_free;
    assign o_q_ready = (r_state == S_IDLE);
    assign o_valid   = r_out_v;
    assign o_result  = r_out;

    assign hole_new = !r_open || (r_start != i_cfg.hole_sector) || (r_len >= i_cfg.hole_cap);
    assign room     = i_cfg.hole_cap - r_len;
    assign step     = (room > 16'(r_left)) ? 16'(r_left) : room;
    assign data_ext = r_open && ((ST_W'(r_start) + ST_W'(r_len)) == r_st) &&
                      ((17'(r_len) + 17'(i_spb)) <= 17'(i_cfg.max_count));
    assign data_err = r_st > ST_W'(i_cfg.max_number);
    assign hole_err = i_cfg.hole_sector > i_cfg.max_number;

    assign close_res = '{start: r_start, length: r_len, index: r_cnt,
                         end_marker: 1'b0, range_error: 1'b0, last: 1'b0};

    assign out_res = '{start: r_pend.start, length: r_pend.length, index: r_pend.index,
                       end_marker: r_pend.end_marker, range_error: r_pend.range_error,
                       last: flush};

    always_comb begin
        emit    = 1'b0;
        flush   = 1'b0;
        new_res = close_res;
        unique case (r_state)
            S_HOLE: begin
                emit = (r_left != '0) && hole_new && r_open && emit_ok;
            end
            S_DATA: begin
                emit = !data_ext && r_open && emit_ok;
            end
            S_FIN: begin
                emit = r_final && emit_ok;
                if (!r_open) begin
                    new_res = '{start: 32'd0, length: 16'd0, index: r_cnt + 16'd1,
                                end_marker: 1'b1, range_error: 1'b0, last: 1'b0};
                end
            end
            S_ERR: begin
                emit    = emit_ok;
                new_res = '{start: r_start, length: 16'd0, index: r_cnt,
                            end_marker: 1'b0, range_error: 1'b1, last: 1'b0};
            end
            S_DONE: begin
                flush = r_pend_v && out_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= '0;
            r_len    <= '0;
            r_open   <= 1'b0;
            r_cnt    <= '0;
            r_halt   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_v <= 1'b0;
            end
            if ((emit && r_pend_v) || flush) begin
                r_out_v <= 1'b1;
                r_out   <= out_res;
            end
            if (emit) begin
                r_pend   <= new_res;
                r_pend_v <= 1'b1;
            end else if (flush) begin
                r_pend_v <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !r_halt) begin
                        r_st    <= i_q_data[ST_W-1:0];
                        r_final <= i_q_data[ST_W];
                        r_left  <= i_spb;
                        r_state <= i_q_data[ST_W+1] ? S_HOLE : S_DATA;
                    end
                end
                S_HOLE: begin
                    if (r_left == '0) begin
                        r_state <= S_FIN;
                    end else if (hole_new) begin
                        if (r_open) begin
                            if (emit_ok) begin
                                r_open <= 1'b0;
                            end
                        end else begin
                            r_cnt   <= r_cnt + 16'd1;
                            r_start <= i_cfg.hole_sector;
                            r_len   <= '0;
                            if (hole_err) begin
                                r_state <= S_ERR;
                            end else begin
                                r_open <= 1'b1;
                            end
                        end
                    end else begin
                        r_len  <= r_len + step;
                        r_left <= r_left - step[SPB_W-1:0];
                    end
                end
                S_DATA: begin
                    if (data_ext) begin
                        r_len   <= r_len + 16'(i_spb);
                        r_state <= S_FIN;
                    end else if (r_open) begin
                        if (emit_ok) begin
                            r_open <= 1'b0;
                        end
                    end else begin
                        r_cnt   <= r_cnt + 16'd1;
                        r_start <= r_st[31:0];
                        r_len   <= 16'(i_spb);
                        if (data_err) begin
                            r_state <= S_ERR;
                        end else begin
                            r_open  <= 1'b1;
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_final) begin
                        r_state <= S_DONE;
                    end else if (emit_ok) begin
                        if (r_open) begin
                            r_open <= 1'b0;
                        end else begin
                            r_cnt   <= '0;
                            r_start <= '0;
                            r_len   <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_ERR: begin
                    if (emit_ok) begin
                        r_halt  <= 1'b1;
                        r_open  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_pend_v || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: src/block_map_extent_coalescer_top.sv
`timescale 1ns / 1ps
// Top level of the block map extent coalescer: configuration registers and stage wiring.
//
// Each transaction on the input stream carries one physical block number, with tlast
// marking the file's final block; the output stream carries the closed sector extents,
// the end marker and any range error, with tlast on the last result of each input
// transaction. The front stage takes one block a cycle, unless the queue backs up, into
// a two-entry queue; the extent sequencer behind it then loads an item, grows, closes or
// opens an extent, checks for the final block and releases the last result, in that
// order. A hole is taken by closing, opening and growing one hole extent after another
// until it is covered. A stalled output holds the sequencer until its result moves on.
// After a range error the block discards all further input until reset.
module block_map_extent_coalescer_top #(
    parameter int MAX_SECTORS_PER_BLOCK = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [31:0]                    i_s_axis_tdata,  // block_number
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [63:0]                    o_m_axis_tdata,  // extent_start, extent_length, entry_index
    output logic [1:0]                     o_m_axis_tuser,  // end_marker, range_error
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bmec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    localparam int SPB_W = $clog2(MAX_SECTORS_PER_BLOCK + 1);
    localparam int CMP_W = (SPB_W > 5) ? SPB_W : 5;
    localparam int ST_W  = 33 + SPB_W;

    logic [4:0]  r_spb;
    logic [31:0] r_partition_start;
    logic [31:0] r_hole_sector;
    logic [15:0] r_max_hole;
    logic [31:0] r_max_number;
    logic [15:0] r_max_count;

    logic [SPB_W-1:0]    spb;
    logic [15:0]         max_count;
    logic [15:0]         hole_cap;
    bmec_pkg::t_back_cfg back_cfg;
    bmec_pkg::t_result   result;

    logic            f_valid;
    logic            f_ready;
    logic [ST_W+1:0] f_data;
    logic            q_valid;
    logic            q_ready;
    logic [ST_W+1:0] q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb             <= 5'd2;
            r_partition_start <= 32'd0;
            r_hole_sector     <= 32'd0;
            r_max_hole        <= 16'd1;
            r_max_number      <= 32'hFFFF_FFFF;
            r_max_count       <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmec_pkg::REG_SECTORS_PER_BLOCK: r_spb             <= i_cfg_data[4:0];
                bmec_pkg::REG_PARTITION_START:   r_partition_start <= i_cfg_data;
                bmec_pkg::REG_HOLE_SECTOR:       r_hole_sector     <= i_cfg_data;
                bmec_pkg::REG_MAX_HOLE_SECTORS:  r_max_hole        <= i_cfg_data[15:0];
                bmec_pkg::REG_MAX_SECTOR_NUMBER: r_max_number      <= i_cfg_data;
                bmec_pkg::REG_MAX_SECTOR_COUNT:  r_max_count       <= i_cfg_data[15:0];
                default: begin
                    r_spb <= r_spb;
                end
            endcase
        end
    end

    always_comb begin
        if (r_spb == 5'd0) begin
            spb = SPB_W'(1);
        end else if (CMP_W'(r_spb) > CMP_W'(MAX_SECTORS_PER_BLOCK)) begin
            spb = SPB_W'(MAX_SECTORS_PER_BLOCK);
        end else begin
            spb = SPB_W'(r_spb);
        end
        max_count = (r_max_count == 16'd0) ? 16'd1 : r_max_count;
        hole_cap  = (r_max_hole == 16'd0) ? 16'd1 : r_max_hole;
        if (hole_cap > max_count) begin
            hole_cap = max_count;
        end
    end

    assign back_cfg = '{hole_sector: r_hole_sector, max_number: r_max_number,
                        hole_cap: hole_cap, max_count: max_count};

    bmec_front #(
        .SPB_W (SPB_W),
        .ST_W  (ST_W)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_axis_tvalid),
        .o_ready           (o_s_axis_tready),
        .i_block_number    (i_s_axis_tdata),
        .i_final_block     (i_s_axis_tlast),
        .i_spb             (spb),
        .i_partition_start (r_partition_start),
        .o_valid           (f_valid),
        .i_ready           (f_ready),
        .o_data            (f_data)
    );

    bmec_queue #(
        .WIDTH (ST_W + 2),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    bmec_back #(
        .SPB_W (SPB_W),
        .ST_W  (ST_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .i_spb     (spb),
        .i_cfg     (back_cfg),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {result.index, result.length, result.start};
    assign o_m_axis_tuser = {result.range_error, result.end_marker};
    assign o_m_axis_tlast = result.last;
endmodule

FILE: src/bmec_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the block map extent coalescer and their binding.
module bmec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transaction withdrawn while stalled");

    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
        o_m_axis_tdata[47:0] == 48'd0 && o_m_axis_tlast && !o_m_axis_tuser[1])
        else $error("malformed end marker");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |->
        o_m_axis_tdata[47:32] == 16'd0 && o_m_axis_tlast)
        else $error("malformed range error result");

    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[1] |=> !o_m_axis_tvalid)
        else $error("result produced after a range error");

    a_extent_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == 2'b00 |-> o_m_axis_tdata[47:32] != 16'd0)
        else $error("extent of zero length");
endmodule

bind block_map_extent_coalescer_top bmec_checker u_bmec_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the block map extent coalescer, with a scoreboard predicting the extent list.
module tb_top;

    localparam int MAX_SPB     = 16;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    class extent_scoreboard;
        bmec_pkg::t_result pending[$];
        bmec_pkg::t_result step_out[$];
        int          errors;
        logic [4:0]  spb_reg;
        logic [31:0] part_start;
        logic [31:0] hole_sec;
        logic [15:0] hole_cap_reg;
        logic [31:0] max_num;
        logic [15:0] max_cnt_reg;
        logic [31:0] cur_start;
        logic [15:0] cur_len;
        bit          cur_open;
        logic [15:0] entry_cnt;
        bit          halted;

        function new();
            spb_reg      = 5'd2;
            part_start   = '0;
            hole_sec     = '0;
            hole_cap_reg = 16'd1;
            max_num      = 32'hFFFF_FFFF;
            max_cnt_reg  = 16'hFFFF;
            cur_start    = '0;
            cur_len      = '0;
            cur_open     = 1'b0;
            entry_cnt    = '0;
            halted       = 1'b0;
            errors       = 0;
        endfunction

        function void write_reg(logic [bmec_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                bmec_pkg::REG_SECTORS_PER_BLOCK: spb_reg      = val[4:0];
                bmec_pkg::REG_PARTITION_START:   part_start   = val;
                bmec_pkg::REG_HOLE_SECTOR:       hole_sec     = val;
                bmec_pkg::REG_MAX_HOLE_SECTORS:  hole_cap_reg = val[15:0];
                bmec_pkg::REG_MAX_SECTOR_NUMBER: max_num      = val;
                bmec_pkg::REG_MAX_SECTOR_COUNT:  max_cnt_reg  = val[15:0];
                default: ;
            endcase
        endfunction

        function void push_entry(logic [63:0] st, logic [15:0] len, logic [15:0] idx,
                                 bit endm, bit err);
            bmec_pkg::t_result r;
            r.start       = st[31:0];
            r.length      = len;
            r.index       = idx;
            r.end_marker  = endm;
            r.range_error = err;
            r.last        = 1'b0;
            step_out.push_back(r);
        endfunction

        // Closes the open extent and opens another; returns 0 when the start is out of range.
        function bit open_extent(logic [63:0] st, logic [15:0] len);
            if (cur_open)
                push_entry({32'd0, cur_start}, cur_len, entry_cnt, 1'b0, 1'b0);
            entry_cnt = entry_cnt + 16'd1;
            if (st > {32'd0, max_num}) begin
                push_entry(st, 16'd0, entry_cnt, 1'b0, 1'b1);
                halted   = 1'b1;
                cur_open = 1'b0;
                return 1'b0;
            end
            cur_start = st[31:0];
            cur_len   = len;
            cur_open  = 1'b1;
            return 1'b1;
        endfunction

        function void note_block(logic [31:0] blk, bit fin);
            int unsigned spb;
            int unsigned mc;
            int unsigned cap;
            int unsigned left;
            int unsigned n;
            logic [63:0] st;
            bit          ok;
            if (halted)
                return;
            step_out.delete();
            ok  = 1'b1;
            spb = spb_reg;
            if (spb == 0)
                spb = 1;
            if (spb > MAX_SPB)
                spb = MAX_SPB;
            mc  = (max_cnt_reg == 0) ? 1 : max_cnt_reg;
            cap = (hole_cap_reg == 0) ? 1 : hole_cap_reg;
            if (cap > mc)
                cap = mc;
            if (blk == 0) begin
                left = spb;
                while (left > 0 && ok) begin
                    if (!cur_open || cur_start != hole_sec || cur_len >= cap)
                        ok = open_extent({32'd0, hole_sec}, 16'd0);
                    if (ok) begin
                        n = cap - cur_len;
                        if (n > left)
                            n = left;
                        cur_len = cur_len + 16'(n);
                        left    = left - n;
                    end
                end
            end else begin
                st = 64'(part_start) + 64'(blk) * 64'(spb);
                if (cur_open && (64'(cur_start) + 64'(cur_len)) == st &&
                    (int'(cur_len) + spb) <= mc)
                    cur_len = cur_len + 16'(spb);
                else
                    ok = open_extent(st, 16'(spb));
            end
            if (ok && fin) begin
                if (cur_open)
                    push_entry({32'd0, cur_start}, cur_len, entry_cnt, 1'b0, 1'b0);
                entry_cnt = entry_cnt + 16'd1;
                push_entry(64'd0, 16'd0, entry_cnt, 1'b1, 1'b0);
                cur_open  = 1'b0;
                cur_start = '0;
                cur_len   = '0;
                entry_cnt = '0;
            end
            if (step_out.size() > 0)
                step_out[step_out.size()-1].last = 1'b1;
            foreach (step_out[k])
                pending.push_back(step_out[k]);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [63:0] tdata, logic [1:0] tuser, logic tlast);
            bmec_pkg::t_result got;
            bmec_pkg::t_result want;
            got.start       = tdata[31:0];
            got.length      = tdata[47:32];
            got.index       = tdata[63:48];
            got.end_marker  = tuser[0];
            got.range_error = tuser[1];
            got.last        = tlast;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected extent start=%h len=%0d idx=%0d",
                                          got.start, got.length, got.index));
                return;
            end
            want = pending.pop_front();
            if (got !== want)
                report_mismatch($sformatf(
                    "got start=%h len=%0d idx=%0d end=%b err=%b last=%b, want %h %0d %0d %b %b %b",
                    got.start, got.length, got.index, got.end_marker, got.range_error,
                    got.last, want.start, want.length, want.index, want.end_marker,
                    want.range_error, want.last));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [63:0]                    m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bmec_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    extent_scoreboard sb = new();
    bit fast_mode;
    bit hold_request;
    int idle_cycles;

    block_map_extent_coalescer_top #(
        .MAX_SECTORS_PER_BLOCK(MAX_SPB)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        if (fast_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_block(input logic [31:0] blk, input bit fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        s_tlast  <= fin;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_block(blk, fin);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [bmec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [4:0] spb, input logic [31:0] pstart,
                             input logic [31:0] hole, input logic [15:0] mhole,
                             input logic [31:0] maxnum, input logic [15:0] mcnt);
        cfg_put(bmec_pkg::REG_SECTORS_PER_BLOCK, {27'd0, spb});
        cfg_put(bmec_pkg::REG_PARTITION_START, pstart);
        cfg_put(bmec_pkg::REG_HOLE_SECTOR, hole);
        cfg_put(bmec_pkg::REG_MAX_HOLE_SECTORS, {16'd0, mhole});
        cfg_put(bmec_pkg::REG_MAX_SECTOR_NUMBER, maxnum);
        cfg_put(bmec_pkg::REG_MAX_SECTOR_COUNT, {16'd0, mcnt});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_file(input int n_items, input bit with_hold);
        logic [4:0]  spb;
        logic [31:0] pstart;
        logic [31:0] hole;
        logic [31:0] maxnum;
        logic [15:0] mhole;
        logic [15:0] mcnt;
        logic [63:0] top;
        logic [31:0] blk_max;
        logic [32:0] next_blk;
        logic [31:0] blk;
        int unsigned spb_eff;
        int          r;
        bit          fin;
        case ($urandom_range(0, 5))
            0:       spb = 5'd1;
            1:       spb = 5'd16;
            2:       spb = 5'd0;
            3:       spb = 5'($urandom_range(17, 31));
            default: spb = 5'($urandom_range(1, 16));
        endcase
        spb_eff = (spb == 0) ? 1 : ((spb > MAX_SPB) ? MAX_SPB : spb);
        case ($urandom_range(0, 3))
            0:       pstart = 32'd0;
            1:       pstart = $urandom;
            2:       pstart = $urandom_range(0, 32'h0010_0000);
            default: pstart = 32'hFFFF_0000;
        endcase
        if (pstart > 32'hFFFF_FF00)
            pstart = 32'hFFFF_FF00;
        if ($urandom_range(0, 1) == 0) begin
            maxnum = 32'hFFFF_FFFF;
        end else begin
            top = 64'(pstart) + 64'($urandom_range(64, 32'h0010_0000));
            maxnum = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
        end
        blk_max  = (maxnum - pstart) / spb_eff;
        next_blk = 33'($urandom_range(1, blk_max));
        case ($urandom_range(0, 3))
            0:       hole = 32'd0;
            1:       hole = maxnum;
            2:       hole = pstart + spb_eff * next_blk[31:0];
            default: hole = $urandom_range(0, maxnum);
        endcase
        if (hole > maxnum)
            hole = maxnum;
        case ($urandom_range(0, 3))
            0:       mhole = 16'd0;
            1:       mhole = 16'd1;
            2:       mhole = 16'hFFFF;
            default: mhole = 16'($urandom_range(1, 48));
        endcase
        case ($urandom_range(0, 4))
            0:       mcnt = 16'd0;
            1:       mcnt = 16'd1;
            2:       mcnt = 16'hFFFF;
            3:       mcnt = 16'($urandom_range(spb_eff, 200));
            default: mcnt = 16'($urandom_range(1, 64));
        endcase
        configure(spb, pstart, hole, mhole, maxnum, mcnt);
        fast_mode = ($urandom_range(0, 3) == 0);
        if (with_hold)
            hold_request = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55 && next_blk >= 1 && next_blk <= {1'b0, blk_max})
                blk = next_blk[31:0];
            else if (r < 75)
                blk = 32'd0;
            else
                blk = $urandom_range(1, blk_max);
            if (blk != 0)
                next_blk = {1'b0, blk} + 33'd1;
            fin = ($urandom_range(0, 14) == 0) || (i == n_items - 1);
            send_block(blk, fin);
        end
        wait_idle();
    endtask

    initial begin
        int          stall_left;
        int          r;
        stall_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (fast_mode) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
            (m_tvalid === 1'b1 && m_tready === 1'b1) ||
            (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        idle_cycles  = 0;
        fast_mode    = 1'b0;
        hold_request = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= bmec_pkg::REG_SECTORS_PER_BLOCK;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: data runs that merge, holes of one sector, and a final hole.
        send_block(32'd5, 1'b0);
        send_block(32'd6, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd9, 1'b1);
        send_block(32'd0, 1'b1);
        send_block(32'd1, 1'b0);
        send_block(32'd3, 1'b1);
        wait_idle();

        // Zero sectors per block and zero limits, with the largest block numbers.
        configure(5'd0, 32'd0, 32'h0000_0100, 16'd0, 32'hFFFF_FFFF, 16'd0);
        send_block(32'hFFFF_FFFF, 1'b0);
        send_block(32'hFFFF_FFFE, 1'b0);
        send_block(32'd7, 1'b0);
        send_block(32'd8, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'h8000_0000, 1'b1);
        wait_idle();

        // Oversized block factor, and holes growing a data extent that begins at the hole sector.
        configure(5'd31, 32'd0, 32'd16, 16'd40, 32'hFFFF_FFFF, 16'hFFFF);
        send_block(32'd1, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd2, 1'b0);
        send_block(32'd0, 1'b1);
        wait_idle();

        // Hole limit above the count limit, and a count limit too small for two blocks to merge.
        configure(5'd16, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd20);
        send_block(32'd0, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd0, 1'b0);
        send_block(32'd3, 1'b0);
        send_block(32'd4, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++)
            run_random_file(57, p == 2);

        // A start beyond 32 bits halts the block; later transactions are discarded.
        configure(5'd16, 32'hFFFF_FFF0, 32'd5, 16'd3, 32'hFFFF_FFFF, 16'd100);
        send_block(32'd0, 1'b0);
        send_block(32'hFFFF_FFFF, 1'b0);
        send_block(32'd7, 1'b0);
        send_block(32'd0, 1'b1);
        wait_idle();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
